// ===== rtl/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// eic_pkg: shared types for the expiring increment counter
// Holds the pending table word layout and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned LIFE_W     = 32;
  localparam int unsigned COUNT_W    = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [LIFE_W-1:0] remaining;
    logic [STEP_W-1:0] amount;
  } eic_entry_t;

  typedef struct packed {
    logic load_in;     // capture the input beat
    logic clr_rej;     // clear the reject flag
    logic scan_clear;  // reset the slot counter
    logic scan_next;   // advance the slot counter
    logic add_total;   // permanent step goes straight into the total
    logic alloc;       // claim the slot under the counter
    logic set_rej;     // table full, flag the beat as rejected
    logic tick_issue;  // read the slot under the counter and advance
    logic out_load;    // load the result register
  } eic_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_keep;
    logic life_zero;
    logic scan_end;
    logic slot_free;
    logic wb_busy;
    logic out_free;
  } eic_sts_t;

endpackage

// ===== rtl/eic_ctrl.sv =====
// ----------------------------------------------------------------------------
// eic_ctrl: sequencer for the expiring increment counter
// Walks each beat through decode, a slot search or a table sweep, and the
// hand-off into the result register.
// ----------------------------------------------------------------------------
module eic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  eic_pkg::eic_sts_t sts,
  output eic_pkg::eic_cmd_t cmd
);
  import eic_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ADD      = 3'd2;
  localparam logic [2:0] S_TICK     = 3'd3;
  localparam logic [2:0] S_FIN      = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.clr_rej = 1'b1;
        if (sts.is_tick) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_TICK;
        end else if (sts.is_keep) begin
          cmd.add_total = 1'b1;
          state_next    = S_FIN;
        end else if (sts.life_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_ADD;
        end
      end
      S_ADD: begin
        if (sts.scan_end) begin
          cmd.set_rej = 1'b1;
          state_next  = S_FIN;
        end else if (sts.slot_free) begin
          cmd.alloc  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_TICK: begin
        if (!sts.scan_end) begin
          cmd.tick_issue = 1'b1;
        end else if (!sts.wb_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/eic_dpath.sv =====
// ----------------------------------------------------------------------------
// eic_dpath: datapath of the expiring increment counter
// Holds the running total, the pending table (valid flags in flip-flops,
// lifetimes and steps in a single-port-write memory) and the result register.
// ----------------------------------------------------------------------------
module eic_dpath #(
  parameter int unsigned PENDING_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  eic_pkg::eic_cmd_t              cmd,
  output eic_pkg::eic_sts_t              sts,
  input  logic                           opcode,
  input  logic [eic_pkg::STEP_W-1:0]     step,
  input  logic [eic_pkg::LIFE_W-1:0]     lifetime,
  input  logic                           permanent,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [eic_pkg::COUNT_W-1:0]    count,
  output logic                           rejected
);
  import eic_pkg::*;

  localparam int unsigned IW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(PENDING_ENTRIES + 1);

  logic                 op_q;
  logic [STEP_W-1:0]    step_q;
  logic [LIFE_W-1:0]    life_q;
  logic                 keep_q;

  logic [TOTAL_W-1:0]   total;
  logic                 rej;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        idx;
  logic [PENDING_ENTRIES-1:0] valid;

  eic_entry_t           mem [PENDING_ENTRIES];
  eic_entry_t           rd_q;
  logic                 p_valid;
  logic [IW-1:0]        p_addr;

  logic                 wb_live;
  logic [LIFE_W-1:0]    rem_dec;
  logic                 expire;

  assign idx     = cnt[IW-1:0];
  assign wb_live = p_valid && valid[p_addr];
  assign rem_dec = rd_q.remaining - LIFE_W'(1);
  assign expire  = wb_live && (rem_dec == '0);

  assign sts.is_tick   = (op_q == OP_TICK);
  assign sts.is_keep   = keep_q;
  assign sts.life_zero = (life_q == '0);
  assign sts.scan_end  = (cnt == CW'(PENDING_ENTRIES));
  assign sts.slot_free = !valid[idx];
  assign sts.wb_busy   = p_valid;
  assign sts.out_free  = !out_valid || out_ready;

  // Captured beat.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= opcode;
      step_q <= step;
      life_q <= lifetime;
      keep_q <= permanent;
    end
  end

  // Slot counter and read pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      p_valid <= 1'b0;
    end else begin
      if (cmd.scan_clear) begin
        cnt <= '0;
      end else if (cmd.scan_next || cmd.tick_issue) begin
        cnt <= cnt + CW'(1);
      end
      p_valid <= cmd.tick_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_issue) begin
      p_addr <= idx;
    end
  end

  // Table memory: one read port for the sweep, one write port.
  always_ff @(posedge clk) begin
    if (cmd.tick_issue) begin
      rd_q <= mem[idx];
    end
    if (cmd.alloc) begin
      mem[idx] <= '{remaining: life_q, amount: step_q};
    end else if (wb_live) begin
      mem[p_addr] <= '{remaining: rem_dec, amount: rd_q.amount};
    end
  end

  // Valid flags, total and reject flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      total <= '0;
      rej   <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        valid[idx] <= 1'b1;
      end else if (expire) begin
        valid[p_addr] <= 1'b0;
      end
      if (cmd.add_total || cmd.alloc) begin
        total <= total + TOTAL_W'(step_q);
      end else if (expire) begin
        total <= total - TOTAL_W'(rd_q.amount);
      end
      if (cmd.clr_rej) begin
        rej <= 1'b0;
      end else if (cmd.set_rej) begin
        rej <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      count    <= total[COUNT_W-1:0];
      rejected <= rej;
    end
  end

endmodule

// ===== rtl/expiring_increment_counter.sv =====
// ----------------------------------------------------------------------------
// expiring_increment_counter: running total with expiring increments
// A permanent or zero-lifetime add goes from decode straight to the result
// register; an expiring add first searches the table one slot per cycle
// for the lowest free slot, and a tick first sweeps every slot in the same way.
// A new beat is taken only after the previous result has been loaded. Reset
// empties the table and clears the total; no clearing pass.
// ----------------------------------------------------------------------------
module expiring_increment_counter #(
  parameter int unsigned PENDING_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [eic_pkg::STEP_W-1:0]  step,
  input  logic [eic_pkg::LIFE_W-1:0]  lifetime,
  input  logic                        permanent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [eic_pkg::COUNT_W-1:0] count,
  output logic                        rejected
);
  import eic_pkg::*;

  // The controller only sequences; all state that the result depends on
  // lives in the datapath.
  eic_cmd_t cmd;
  eic_sts_t sts;

  // An input beat is taken only in the idle state, but the result register
  // is separate, so a new beat can be taken while the previous result is
  // still waiting for the consumer.
  eic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The expiring add searches the valid flags from slot zero upwards, so the
  // lowest free slot is taken. A tick sweeps every slot through a registered
  // memory read, with the decremented lifetime written back in the following cycle.
  eic_dpath #(
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .opcode    (opcode),
    .step      (step),
    .lifetime  (lifetime),
    .permanent (permanent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .count     (count),
    .rejected  (rejected)
  );

  // A slot is claimed only when it is free and the search is still in range.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> (sts.slot_free && !sts.scan_end))
    else $error("slot claimed while occupied or beyond the table");

  // The sweep never reads beyond the last slot.
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_issue |-> !sts.scan_end)
    else $error("table sweep ran past the last slot");

  // A result is loaded only when the result register can take it.
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before it was taken");

  // Once a beat is taken the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while the first was in progress");

endmodule

// ===== verif/expiring_increment_counter_tb.sv =====
// ----------------------------------------------------------------------------
// expiring_increment_counter_tb: self-checking bench for the expiring counter
// Drives add and tick beats through the valid/ready input channel. A local
// sliding-window model predicts every result. Each returned beat is compared
// with the oldest prediction. The sender runs in random bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module expiring_increment_counter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import eic_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam longint     TIMEOUT_NS  = 10_000_000;

  // One input beat and one result beat, at the block's own widths.
  typedef struct packed {
    logic              op;
    logic [STEP_W-1:0] step;
    logic [LIFE_W-1:0] life;
    logic              keep;
  } beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               rejected;
  } tally_t;

  // The receiver switches between these stall behaviours.
  typedef enum int unsigned {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_CYCLIC
  } rx_mode_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               opcode    = OP_ADD;
  logic [STEP_W-1:0]  step      = '0;
  logic [LIFE_W-1:0]  lifetime  = '0;
  logic               permanent = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] count;
  logic               rejected;

  // Local copy of the window: the total, and which slots hold a pending step
  // with how many ticks it has left.
  logic [TOTAL_W-1:0] win_total = '0;
  logic               slot_busy [SLOTS];
  logic [LIFE_W-1:0]  slot_ttl  [SLOTS];
  logic [STEP_W-1:0]  slot_step [SLOTS];

  tally_t      pending_tallies [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  rx_mode_t    rx_mode    = RX_OPEN;
  int unsigned rx_left    = 0;

  expiring_increment_counter #(
    .PENDING_ENTRIES(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .step(step),
    .lifetime(lifetime),
    .permanent(permanent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .count(count),
    .rejected(rejected)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one beat to the local window and returns the result it should
  // produce. A tick counts every pending lifetime down and removes the steps
  // that reach zero; an expiring add takes the lowest free slot or is turned
  // away when none is left. A zero lifetime expires at once, so it changes
  // nothing and is never rejected, even with the table full.
  function automatic tally_t window_after(input beat_t b);
    tally_t t;
    int     free_slot;
    t.rejected = 1'b0;
    free_slot  = -1;
    if (b.op == OP_TICK) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_busy[s]) begin
          slot_ttl[s] = slot_ttl[s] - LIFE_W'(1);
          if (slot_ttl[s] == '0) begin
            win_total    = win_total - TOTAL_W'(slot_step[s]);
            slot_busy[s] = 1'b0;
          end
        end
      end
    end else if (b.keep) begin
      win_total = win_total + TOTAL_W'(b.step);
    end else if (b.life != '0) begin
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (!slot_busy[s]) free_slot = s;
      end
      if (free_slot < 0) begin
        t.rejected = 1'b1;
      end else begin
        slot_busy[free_slot] = 1'b1;
        slot_ttl[free_slot]  = b.life;
        slot_step[free_slot] = b.step;
        win_total            = win_total + TOTAL_W'(b.step);
      end
    end
    t.count = win_total[COUNT_W-1:0];
    return t;
  endfunction

  function automatic beat_t add_beat(input logic [STEP_W-1:0] amt,
                                     input logic [LIFE_W-1:0] ttl,
                                     input logic keep);
    beat_t b;
    b.op   = OP_ADD;
    b.step = amt;
    b.life = ttl;
    b.keep = keep;
    return b;
  endfunction

  // A tick carries random junk in the fields it should ignore.
  function automatic beat_t tick_beat();
    beat_t b;
    b.op   = OP_TICK;
    b.step = STEP_W'($urandom());
    b.life = $urandom();
    b.keep = 1'(($urandom()));
    return b;
  endfunction

  // Steps lean towards the two extremes now and then.
  function automatic logic [STEP_W-1:0] pick_step();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return STEP_W'($urandom());
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Bursts of back-to-back beats with random gaps between them; some bursts
  // are long, so there are stretches with no idling at all.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  // Presents one beat, holds it until it is taken, then records what the
  // window should answer. Always entered and left at a rising edge.
  task automatic send_beat(input beat_t b);
    in_valid  <= 1'b1;
    opcode    <= b.op;
    step      <= b.step;
    lifetime  <= b.life;
    permanent <= b.keep;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_tallies.push_back(window_after(b));
    pace();
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_tick();
    send_beat(tick_beat());
    drain();
  endtask

  task automatic test_permanent_steps();
    send_beat(add_beat('1, '1, 1'b1));
    send_beat(add_beat('0, '0, 1'b1));
    drain();
  endtask

  task automatic test_zero_lifetime();
    send_beat(add_beat(8'd200, '0, 1'b0));
    drain();
  endtask

  // A lifetime of one goes at the very next tick; two survives one tick.
  task automatic test_expiry_edge();
    send_beat(add_beat(8'd17, 32'd1, 1'b0));
    send_beat(tick_beat());
    send_beat(add_beat(8'd33, 32'd2, 1'b0));
    send_beat(tick_beat());
    send_beat(tick_beat());
    drain();
  endtask

  // Fill every slot, then show that one more expiring step is turned away
  // while a zero-lifetime step is not, and that one tick empties the table.
  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++) begin
      send_beat(add_beat((i % 2 == 0) ? 8'd255 : 8'd0, 32'd1, 1'b0));
    end
    send_beat(add_beat(pick_step(), 32'd7, 1'b0));
    send_beat(add_beat(pick_step(), '0, 1'b0));
    send_beat(tick_beat());
    drain();
  endtask

  // Mostly large permanent steps, enough to carry the 16-bit count past
  // its top and round again.
  task automatic test_count_rollover();
    for (int i = 0; i < 330; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(tick_beat());
      else send_beat(add_beat(STEP_W'($urandom_range(220, 255)), $urandom(), 1'b1));
    end
    drain();
  endtask

  // Segments with different tick densities: add-heavy ones fill the table
  // and provoke rejections, tick-heavy ones empty it again.
  task automatic test_random_mix(input int unsigned beats);
    int unsigned tick_pct;
    int unsigned seg_left;
    int unsigned roll;
    logic [LIFE_W-1:0] ttl;
    seg_left = 0;
    tick_pct = 30;
    for (int unsigned i = 0; i < beats; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       tick_pct = 10;
          1:       tick_pct = 35;
          default: tick_pct = 60;
        endcase
      end
      seg_left--;
      if ($urandom_range(0, 99) < tick_pct) begin
        send_beat(tick_beat());
      end else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) ttl = '0;
        else if (roll < 15) ttl = $urandom_range(1, 8);
        else ttl = $urandom_range(9, 40);
        send_beat(add_beat(pick_step(), ttl, $urandom_range(0, 4) == 0));
      end
    end
    drain();
  endtask

  // Full-width lifetimes; these steps stay for good, so this runs last. The
  // table fills up quickly and the rest of the expiring adds are rejected.
  task automatic test_long_lifetimes();
    send_beat(add_beat('1, '1, 1'b0));
    for (int i = 0; i < 220; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_beat(tick_beat());
        3:       send_beat(add_beat(pick_step(), $urandom(), 1'b1));
        default: send_beat(add_beat(pick_step(), $urandom(), 1'b0));
      endcase
    end
    drain();
  endtask

  // Receiver: runs of open flow, light and heavy random stalls, and a fixed
  // three-in-seven stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(30, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
        default:  out_ready <= ((rx_left % 7) > 2);
      endcase
    end
  end

  // Every result beat taken is matched against the oldest prediction.
  always @(posedge clk) begin : compare_results
    tally_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d rejected=%0b",
                                  count, rejected));
      end else begin
        want = pending_tallies.pop_front();
        if (count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
        if (rejected !== want.rejected)
          report_mismatch($sformatf("rejected %b, expected %b", rejected, want.rejected));
      end
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_tick();
    test_permanent_steps();
    test_zero_lifetime();
    test_expiry_edge();
    test_table_full();
    test_count_rollover();
    test_random_mix(1380);
    test_long_lifetimes();
    drain();
    // A tick is the slowest beat; allow that long for any stray result.
    repeat (SLOTS + 12) @(posedge clk);
    if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
